@@ rtl/ultrasonic_ranging_controller_top_defines.svh @@
// Assertion macros shared by the ultrasonic ranging controller RTL
`ifndef ULTRASONIC_RANGING_CONTROLLER_TOP_DEFINES_SVH
`define ULTRASONIC_RANGING_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define URC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("urc assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset
`define URC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("urc assertion failed");

`endif

@@ rtl/urc_pkg.sv @@
// Package: constants, types and state encoding of the ultrasonic ranging controller
`timescale 1ns / 1ps

package urc_pkg;

  // Field and counter widths
  localparam int COUNT_WIDTH = 16;
  localparam int TICKS_WIDTH = 16;
  localparam int DIST_WIDTH  = 10;
  localparam int PHASE_WIDTH = 2;

  // Trigger length after reset, in ticks
  localparam logic [TICKS_WIDTH-1:0] TRIG_TICKS_RESET = 16'd5000;

  // Phase codes as seen on the result channel
  localparam logic [PHASE_WIDTH-1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [PHASE_WIDTH-1:0] PHASE_CODE_WAIT = 2'd1;
  localparam logic [PHASE_WIDTH-1:0] PHASE_CODE_TIME = 2'd2;

  // Distance math: mm = floor(floor(343 * count / 256) / 125)
  localparam int SOUND_MUL   = 343;
  localparam int DIV_SHIFT   = 8;
  localparam int DIV_REM     = 125;
  // 524 / 2^16 sits just below 1/125; one correction step fixes the quotient
  localparam int RECIP_MUL   = 524;
  localparam int RECIP_SHIFT = 16;
  // Smallest count whose distance exceeds the 10-bit range
  localparam int SAT_COUNT   = 95534;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

  // Datapath widths of the distance pipeline
  localparam int CALC_W       = 17;
  localparam int COUNT_EXT_W  = (COUNT_WIDTH > CALC_W) ? COUNT_WIDTH : CALC_W;
  localparam int PROD_W       = CALC_W + 9;
  localparam int Y_W          = PROD_W - DIV_SHIFT;
  localparam int RECIP_PROD_W = Y_W + 10;
  localparam int Q0_W         = RECIP_PROD_W - RECIP_SHIFT;

  // Measurement phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_TIME = 3'b100
  } phase_e;

  // Result fields that bypass the distance math
  typedef struct packed {
    logic                   trigger_out;
    logic                   distance_valid;
    logic [PHASE_WIDTH-1:0] phase;
  } urc_side_t;

  // Per-tick record from the control stage to the distance pipeline
  typedef struct packed {
    urc_side_t              side;
    logic [COUNT_WIDTH-1:0] dist_count;
  } urc_rec_t;

  // Finished result
  typedef struct packed {
    logic                   trigger_out;
    logic                   distance_valid;
    logic [DIST_WIDTH-1:0]  distance_value;
    logic [PHASE_WIDTH-1:0] phase;
  } urc_res_t;

endpackage

@@ rtl/urc_intf.sv @@
// Channel interfaces: tick input, result output and configuration write
`timescale 1ns / 1ps

// One timer tick with sampled pins and read request
interface urc_in_if;
  logic valid;
  logic ready;
  logic button_level;
  logic echo_level;
  logic take_distance;

  modport source (output valid, output button_level, output echo_level,
                  output take_distance, input ready);
  modport sink   (input valid, input button_level, input echo_level,
                  input take_distance, output ready);
endinterface

// One result per tick
interface urc_out_if import urc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   trigger_out;
  logic                   distance_valid;
  logic [DIST_WIDTH-1:0]  distance_value;
  logic [PHASE_WIDTH-1:0] phase;

  modport source (output valid, output trigger_out, output distance_valid,
                  output distance_value, output phase, input ready);
  modport sink   (input valid, input trigger_out, input distance_valid,
                  input distance_value, input phase, output ready);
endinterface

// Trigger length register write
interface urc_cfg_if import urc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [TICKS_WIDTH-1:0] trigger_ticks;

  modport source (output valid, output trigger_ticks, input ready);
  modport sink   (input valid, input trigger_ticks, output ready);
endinterface

@@ rtl/urc_ctrl.sv @@
// Control stage: edge detection, phase machine, trigger countdown and echo counter
`timescale 1ns / 1ps
`include "ultrasonic_ranging_controller_top_defines.svh"

module urc_ctrl import urc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tick input
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   button_i,
  input  logic                   echo_i,
  input  logic                   take_i,
  // trigger length write
  input  logic                   cfg_we_i,
  input  logic [TICKS_WIDTH-1:0] cfg_data_i,
  // record toward the distance pipeline
  output logic                   rec_valid_o,
  input  logic                   rec_ready_i,
  output urc_rec_t               rec_o
);

  phase_e                 phase_q, phase_d;
  logic                   prev_button_q, prev_echo_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [TICKS_WIDTH-1:0] tl_q, tl_d, tl_mid;
  logic [TICKS_WIDTH-1:0] trig_ticks_q;
  logic [COUNT_WIDTH-1:0] last_cnt_q, last_cnt_d;
  logic                   ready_q, ready_d, ready_mid;
  logic                   rise, fall, release_ev;
  logic                   trig;
  logic                   acc;
  logic                   rec_valid_q;
  urc_rec_t               rec_d, rec_q;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = !rec_valid_q || rec_ready_i;

  // Pin edges against the previous tick
  assign rise       = !prev_echo_q && echo_i;
  assign fall       = prev_echo_q && !echo_i;
  assign release_ev = prev_button_q && !button_i;
  assign cnt_inc    = cnt_q + COUNT_WIDTH'(1);

  // Next state for one tick
  always_comb begin
    phase_d    = phase_q;
    tl_mid     = tl_q;
    cnt_d      = cnt_q;
    last_cnt_d = last_cnt_q;
    ready_mid  = ready_q;
    case (phase_q)
      PH_IDLE: begin
        if (release_ev) begin
          tl_mid  = trig_ticks_q;
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // echo start cuts the trigger short
        if (rise) begin
          tl_mid  = '0;
          cnt_d   = '0;
          phase_d = PH_TIME;
        end
      end
      PH_TIME: begin
        cnt_d = cnt_inc;
        if (fall) begin
          last_cnt_d = cnt_inc;
          ready_mid  = 1'b1;
          phase_d    = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    trig = (tl_mid != '0);
    tl_d = trig ? (tl_mid - TICKS_WIDTH'(1)) : '0;

    // read request sees a distance finished this tick
    rec_d.side.trigger_out    = trig;
    rec_d.side.distance_valid = take_i && ready_mid;
    rec_d.dist_count          = last_cnt_d;
    ready_d                   = take_i ? 1'b0 : ready_mid;

    case (phase_d)
      PH_WAIT: rec_d.side.phase = PHASE_CODE_WAIT;
      PH_TIME: rec_d.side.phase = PHASE_CODE_TIME;
      default: rec_d.side.phase = PHASE_CODE_IDLE;
    endcase
  end

  // Control state, updated per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      prev_button_q <= 1'b0;
      prev_echo_q   <= 1'b0;
      cnt_q         <= '0;
      tl_q          <= '0;
      ready_q       <= 1'b0;
    end else if (acc) begin
      phase_q       <= phase_d;
      prev_button_q <= button_i;
      prev_echo_q   <= echo_i;
      cnt_q         <= cnt_d;
      tl_q          <= tl_d;
      ready_q       <= ready_d;
    end
  end

  // Trigger length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TRIG_TICKS_RESET;
    end else if (cfg_we_i) begin
      trig_ticks_q <= cfg_data_i;
    end
  end

  // Output record valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
    end else if (acc) begin
      rec_valid_q <= 1'b1;
    end else if (rec_ready_i) begin
      rec_valid_q <= 1'b0;
    end
  end

  // Payload: last echo width and output record
  always_ff @(posedge clk_i) begin
    if (acc) begin
      last_cnt_q <= last_cnt_d;
      rec_q      <= rec_d;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

  // Trigger runs only while waiting for the echo
  `URC_ASSERT_NOW(a_trig_in_wait, tl_q != '0, phase_q == PH_WAIT)
  // A read request always clears the ready flag
  `URC_ASSERT_NEXT(a_take_clears, acc && take_i, !ready_q)
  // Echo end without a read leaves a distance pending
  `URC_ASSERT_NEXT(a_fall_sets_ready, acc && phase_q == PH_TIME && fall && !take_i, ready_q)

endmodule

@@ rtl/urc_dist.sv @@
// Distance pipeline: echo width to millimeters in three registered steps
`timescale 1ns / 1ps
`include "ultrasonic_ranging_controller_top_defines.svh"

module urc_dist import urc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  urc_rec_t rec_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output urc_res_t res_o
);

  logic                   s2_v_q, s3_v_q, out_v_q;
  logic                   s2_rdy, s3_rdy, out_rdy;
  urc_side_t              s2_side_q, s3_side_q;
  logic                   s2_sat_q, s3_sat_q;
  logic [Y_W-1:0]         s2_y_q, s3_y_q;
  logic [Q0_W-1:0]        s3_q0_q;
  urc_res_t               res_q, res_d;

  logic [COUNT_EXT_W-1:0]  c_ext;
  logic                    sat;
  logic [PROD_W-1:0]       p;
  logic [RECIP_PROD_W-1:0] rp;
  logic [Y_W-1:0]          m, r;
  logic [Q0_W-1:0]         q;

  // Ready chain: a stage moves when empty or when the next one moves
  assign out_rdy    = !out_v_q || out_ready_i;
  assign s3_rdy     = !s3_v_q || out_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign in_ready_o = s2_rdy;

  // Step 1: saturation check and 343 * count / 256
  assign c_ext = COUNT_EXT_W'(rec_i.dist_count);
  assign sat   = (c_ext >= COUNT_EXT_W'(SAT_COUNT));
  assign p     = PROD_W'(c_ext[CALC_W-1:0]) * PROD_W'(SOUND_MUL);

  // Step 2: reciprocal estimate of y / 125, low by at most one
  assign rp = RECIP_PROD_W'(s2_y_q) * RECIP_PROD_W'(RECIP_MUL);

  // Step 3: remainder check and correction
  assign m = Y_W'(s3_q0_q) * Y_W'(DIV_REM);
  assign r = s3_y_q - m;
  assign q = s3_q0_q + Q0_W'(r >= Y_W'(DIV_REM));

  always_comb begin
    res_d.trigger_out    = s3_side_q.trigger_out;
    res_d.distance_valid = s3_side_q.distance_valid;
    res_d.phase          = s3_side_q.phase;
    if (!s3_side_q.distance_valid) begin
      res_d.distance_value = '0;
    end else if (s3_sat_q) begin
      res_d.distance_value = DIST_MAX;
    end else begin
      res_d.distance_value = q[DIST_WIDTH-1:0];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_rdy) s2_v_q <= in_valid_i;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (out_rdy) out_v_q <= s3_v_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (s2_rdy && in_valid_i) begin
      s2_side_q <= rec_i.side;
      s2_sat_q  <= sat;
      s2_y_q    <= p[PROD_W-1:DIV_SHIFT];
    end
    if (s3_rdy && s2_v_q) begin
      s3_side_q <= s2_side_q;
      s3_sat_q  <= s2_sat_q;
      s3_y_q    <= s2_y_q;
      s3_q0_q   <= rp[RECIP_PROD_W-1:RECIP_SHIFT];
    end
    if (out_rdy && s3_v_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

  // No distance is shown without a pending measurement behind it
  `URC_ASSERT_NOW(a_dist_zero, out_v_q && !res_q.distance_valid, res_q.distance_value == '0)
  // Correction leaves a remainder below the divisor
  `URC_ASSERT_NOW(a_rem_range, s3_v_q && s3_side_q.distance_valid && !s3_sat_q,
                  (r - ((r >= Y_W'(DIV_REM)) ? Y_W'(DIV_REM) : '0)) < Y_W'(DIV_REM))

endmodule

@@ rtl/ultrasonic_ranging_controller_top.sv @@
// Ultrasonic ranging controller top level: pulse trigger, echo timing, distance readout
//
// One tick transfer in gives one result transfer out, in order. A new tick is taken every
// clock cycle while no stall holds the stages; a result passes through the registered control
// stage and then the three-step distance pipeline, which turns the echo width into millimeters
// with constant multiplies and one correction step. Stalls on the result side back up through
// the stages; a tick is still taken while any stage has a free slot. The trigger length register
// (reset 5000 ticks) is written through its own channel, which is always ready.
`timescale 1ns / 1ps

module ultrasonic_ranging_controller_top import urc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  urc_in_if.sink    in_ch,
  urc_out_if.source out_ch,
  urc_cfg_if.sink   cfg_ch
);

  logic     rec_valid;
  logic     rec_ready;
  urc_rec_t rec;
  urc_res_t res;

  // Register writes are taken at once
  assign cfg_ch.ready = 1'b1;

  urc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .button_i    (in_ch.button_level),
    .echo_i      (in_ch.echo_level),
    .take_i      (in_ch.take_distance),
    .cfg_we_i    (cfg_ch.valid),
    .cfg_data_i  (cfg_ch.trigger_ticks),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  urc_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rec_valid),
    .in_ready_o  (rec_ready),
    .rec_i       (rec),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .res_o       (res)
  );

  // Result fields
  assign out_ch.trigger_out    = res.trigger_out;
  assign out_ch.distance_valid = res.distance_valid;
  assign out_ch.distance_value = res.distance_value;
  assign out_ch.phase          = res.phase;

endmodule
